@@ rtl/rdp_pkg.sv @@
// Package for the ring deque pair-pop block: sizes, command codes, queue word
// and back-end state types. No dependencies.
package rdp_pkg;

  localparam int unsigned Depth = 1024;
  localparam int unsigned PtrW  = $clog2(Depth);

  typedef logic [PtrW-1:0] ptr_t;

  // command codes on the input channel
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [1:0] CMD_POP_PAIR   = 2'd2;
  localparam logic [1:0] CMD_RESERVED   = 2'd3;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_PAIR
  } rdp_op_e;

  // word handed from the front end to the back end
  typedef struct packed {
    logic               valid;
    rdp_op_e            op;
    logic signed [31:0] value;
  } rdp_q_t;

  // deque status seen by the top level
  typedef struct packed {
    logic empty;
    logic full;
  } rdp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_BACK,
    ST_SUM_PAIR,
    ST_SUM_ONE
  } rdp_state_e;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(Depth - 1)) r = '0;
    else r = p + ptr_t'(1);
    return r;
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    ptr_t r;
    if (p == '0) r = ptr_t'(Depth - 1);
    else r = p - ptr_t'(1);
    return r;
  endfunction

endpackage

@@ rtl/rdp_if.sv @@
// Valid/ready channel interfaces for the command and result words.
// Depends on nothing.
interface rdp_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] value;
  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface rdp_res_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] pair_sum;
  logic               was_empty;
  modport source (output valid, output pair_sum, output was_empty, input ready);
  modport sink   (input valid, input pair_sum, input was_empty, output ready);
endinterface

@@ rtl/rdp_front.sv @@
// Front end: accepts command words, drops the reserved code and queues the
// rest in a two-entry queue. Depends on rdp_pkg and rdp_cmd_if.
module rdp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  rdp_cmd_if.sink        cmd_i,
  output rdp_pkg::rdp_q_t q_o,
  input  logic           q_pop_i
);

  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         cnt_q, cnt_d;
  rdp_pkg::rdp_op_e   op_q [2];
  logic signed [31:0] val_q [2];
  rdp_pkg::rdp_op_e   in_op;
  logic               in_keep;
  logic               enq;
  logic               deq;

  always_comb begin
    in_op   = rdp_pkg::OP_PUSH_FRONT;
    in_keep = 1'b1;
    case (cmd_i.cmd)
      rdp_pkg::CMD_PUSH_FRONT: in_op = rdp_pkg::OP_PUSH_FRONT;
      rdp_pkg::CMD_PUSH_BACK:  in_op = rdp_pkg::OP_PUSH_BACK;
      rdp_pkg::CMD_POP_PAIR:   in_op = rdp_pkg::OP_POP_PAIR;
      default:                 in_keep = 1'b0;
    endcase
  end

  assign cmd_i.ready = (cnt_q != 2'd2);
  assign enq = cmd_i.valid && cmd_i.ready && in_keep;
  assign deq = q_pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = enq ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(enq) - 2'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      op_q[wr_ptr_q]  <= in_op;
      val_q[wr_ptr_q] <= cmd_i.value;
    end
  end

  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.op    = op_q[rd_ptr_q];
  assign q_o.value = val_q[rd_ptr_q];

endmodule

@@ rtl/rdp_back.sv @@
// Back end: slot memory, front/back pointers, empty/full flags, pop sequencer
// and result register. Depends on rdp_pkg and rdp_res_if.
module rdp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rdp_pkg::rdp_q_t   q_i,
  output logic              q_pop_o,
  rdp_res_if.source         res_o,
  output rdp_pkg::rdp_stat_t stat_o
);

  rdp_pkg::rdp_state_e state_q, state_d;
  rdp_pkg::ptr_t       front_q, front_d;
  rdp_pkg::ptr_t       back_q, back_d;
  logic                empty_q, empty_d;
  logic                full_q, full_d;
  logic signed [31:0]  fval_q, fval_d;

  logic signed [31:0]  mem [rdp_pkg::Depth];
  logic signed [31:0]  rdata_q;
  logic                mem_we, mem_re;
  rdp_pkg::ptr_t       mem_addr;

  logic                res_valid_q;
  logic signed [32:0]  res_sum_q, load_sum;
  logic                res_empty_q, load_empty;
  logic                load;
  logic                out_free;

  rdp_pkg::ptr_t       f_inc, f_dec, b_inc, b_dec;

  assign f_inc = rdp_pkg::ptr_inc(front_q);
  assign f_dec = rdp_pkg::ptr_dec(front_q);
  assign b_inc = rdp_pkg::ptr_inc(back_q);
  assign b_dec = rdp_pkg::ptr_dec(back_q);

  assign out_free = !res_valid_q || res_o.ready;

  always_comb begin
    state_d    = state_q;
    front_d    = front_q;
    back_d     = back_q;
    empty_d    = empty_q;
    full_d     = full_q;
    fval_d     = fval_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = front_q;
    q_pop_o    = 1'b0;
    load       = 1'b0;
    load_sum   = '0;
    load_empty = 1'b0;
    case (state_q)
      rdp_pkg::ST_IDLE: begin
        if (q_i.valid) begin
          case (q_i.op)
            rdp_pkg::OP_PUSH_FRONT: begin
              q_pop_o = 1'b1;
              if (!full_q) begin
                mem_we   = 1'b1;
                mem_addr = f_dec;
                front_d  = f_dec;
                empty_d  = 1'b0;
                full_d   = (f_dec == back_q);
              end
            end
            rdp_pkg::OP_PUSH_BACK: begin
              q_pop_o = 1'b1;
              if (!full_q) begin
                mem_we   = 1'b1;
                mem_addr = back_q;
                back_d   = b_inc;
                empty_d  = 1'b0;
                full_d   = (b_inc == front_q);
              end
            end
            rdp_pkg::OP_POP_PAIR: begin
              // start a pop only once the result register can take it
              if (out_free) begin
                q_pop_o = 1'b1;
                if (empty_q) begin
                  load       = 1'b1;
                  load_empty = 1'b1;
                end else begin
                  mem_re   = 1'b1;
                  mem_addr = front_q;
                  front_d  = f_inc;
                  full_d   = 1'b0;
                  if (f_inc == back_q) begin
                    empty_d = 1'b1;
                    state_d = rdp_pkg::ST_SUM_ONE;
                  end else begin
                    back_d  = b_dec;
                    empty_d = (f_inc == b_dec);
                    state_d = rdp_pkg::ST_RD_BACK;
                  end
                end
              end
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      rdp_pkg::ST_RD_BACK: begin
        // front word lands now; back pointer already moved to the back slot
        mem_re   = 1'b1;
        mem_addr = back_q;
        fval_d   = rdata_q;
        state_d  = rdp_pkg::ST_SUM_PAIR;
      end
      rdp_pkg::ST_SUM_PAIR: begin
        load     = 1'b1;
        load_sum = {fval_q[31], fval_q} + {rdata_q[31], rdata_q};
        state_d  = rdp_pkg::ST_IDLE;
      end
      rdp_pkg::ST_SUM_ONE: begin
        load     = 1'b1;
        load_sum = {rdata_q[31], rdata_q} + {rdata_q[31], rdata_q};
        state_d  = rdp_pkg::ST_IDLE;
      end
      default: state_d = rdp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdp_pkg::ST_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      empty_q     <= 1'b1;
      full_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      back_q  <= back_d;
      empty_q <= empty_d;
      full_q  <= full_d;
      if (load) res_valid_q <= 1'b1;
      else if (res_o.ready) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    fval_q <= fval_d;
    if (load) begin
      res_sum_q   <= load_sum;
      res_empty_q <= load_empty;
    end
  end

  // single-port slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= q_i.value;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.pair_sum  = res_sum_q;
  assign res_o.was_empty = res_empty_q;

  assign stat_o.empty = empty_q;
  assign stat_o.full  = full_q;

endmodule

@@ rtl/ring_deque_pair_pop_core.sv @@
// Ring deque with pair pop: command channel in, result channel out.
// Usage:
//   cmd_i carries a command word (cmd, value): push front, push back or pop
//   pair. Code 3 is taken and ignored. Pushes give no result; a push on a
//   full deque is dropped. Each pop pair gives one word on res_o: the 33-bit
//   sum of front and back, twice the value if one element was held, or
//   was_empty set with a zero sum if the deque was empty.
//   Words enter a two-entry queue; the back end takes one each cycle for
//   pushes while it is idle. A pop pair occupies the back end in its states
//   idle, read back and sum pair (two reads of the single-port slot memory
//   with registered read data), idle and sum one with one element held, and
//   idle alone if empty; then the result register drives res_o valid. Other
//   words wait in the queue until the back end is idle again.
//   If res_o stalls, one result is held; the next pop waits in the queue,
//   and cmd_i ready drops once the queue holds two words.
//   Reset clears pointers and sets empty; the slot memory is not cleared, and
//   no unwritten slot is ever read.
// Depends on rdp_pkg, rdp_if, rdp_front and rdp_back.
module ring_deque_pair_pop_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  rdp_cmd_if.sink   cmd_i,
  rdp_res_if.source res_o
);

  rdp_pkg::rdp_q_t    q;
  logic               q_pop;
  rdp_pkg::rdp_stat_t stat;

  rdp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .q_o     (q),
    .q_pop_i (q_pop)
  );

  rdp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_i     (q),
    .q_pop_o (q_pop),
    .res_o   (res_o),
    .stat_o  (stat)
  );

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.empty && stat.full))
    else $error("deque empty and full at once");

  a_pop_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q.valid)
    else $error("back end took a word from an empty queue");

  a_empty_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.was_empty |-> res_o.pair_sum == 33'sd0)
    else $error("empty pop result carries a nonzero sum");

  a_reserved_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready && cmd_i.cmd == rdp_pkg::CMD_RESERVED && !q.valid
    |=> !q.valid)
    else $error("reserved command entered the queue");

endmodule

@@ bench/rdp_pair_sum_checker.sv @@
// Checker for the ring deque pair-pop core: watches both channels, keeps its
// own copy of the deque and compares every result word with the predicted one.
// Depends on rdp_pkg and rdp_if.
module rdp_pair_sum_checker
  import rdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rdp_cmd_if          cmd_i,
  rdp_res_if          res_i,
  output int unsigned fail_cnt_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    logic signed [32:0] sum;
    logic               empty;
  } pair_result_t;

  pair_result_t sums_due[$];

  logic [31:0] slot_copy [Depth];
  ptr_t        head_idx;
  ptr_t        tail_idx;
  logic        held_none;
  logic        held_all;
  int unsigned mismatches;

  function automatic ptr_t step_up(ptr_t p);
    return ptr_t'((int'(p) + 1) % int'(Depth));
  endfunction

  function automatic ptr_t step_down(ptr_t p);
    return ptr_t'((int'(p) + int'(Depth) - 1) % int'(Depth));
  endfunction

  task automatic predict_word(input logic [1:0] op, input logic [31:0] val);
    logic [31:0]  front_v;
    logic [31:0]  back_v;
    pair_result_t due;
    case (op)
      CMD_PUSH_FRONT: begin
        if (!held_all) begin
          head_idx = step_down(head_idx);
          slot_copy[head_idx] = val;
          held_none = 1'b0;
          if (head_idx == tail_idx) held_all = 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (!held_all) begin
          slot_copy[tail_idx] = val;
          tail_idx = step_up(tail_idx);
          held_none = 1'b0;
          if (tail_idx == head_idx) held_all = 1'b1;
        end
      end
      CMD_POP_PAIR: begin
        if (held_none) begin
          due.sum   = '0;
          due.empty = 1'b1;
        end else begin
          held_all = 1'b0;
          front_v  = slot_copy[head_idx];
          head_idx = step_up(head_idx);
          if (head_idx == tail_idx) begin
            // single element: it is both ends
            held_none = 1'b1;
            back_v    = front_v;
          end else begin
            tail_idx = step_down(tail_idx);
            back_v   = slot_copy[tail_idx];
            if (head_idx == tail_idx) held_none = 1'b1;
          end
          due.sum   = $signed({front_v[31], front_v}) + $signed({back_v[31], back_v});
          due.empty = 1'b0;
        end
        sums_due.push_back(due);
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input pair_result_t due,
                               input logic signed [32:0] got_sum, input logic got_empty);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: result word %s: expected sum %0d empty %0b, got sum %0d empty %0b",
               $realtime, what, due.sum, due.empty, got_sum, got_empty);
  endtask

  task automatic check_word(input logic signed [32:0] got_sum, input logic got_empty);
    pair_result_t due;
    if (sums_due.size() == 0) begin
      due = '0;
      note_mismatch("with none due", due, got_sum, got_empty);
    end else begin
      due = sums_due.pop_front();
      if (due.sum !== got_sum) note_mismatch("pair_sum wrong", due, got_sum, got_empty);
      if (due.empty !== got_empty) note_mismatch("was_empty wrong", due, got_sum, got_empty);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      head_idx   = '0;
      tail_idx   = '0;
      held_none  = 1'b1;
      held_all   = 1'b0;
      mismatches = 0;
      sums_due.delete();
    end else begin
      if (res_i.valid && res_i.ready) check_word(res_i.pair_sum, res_i.was_empty);
      if (cmd_i.valid && cmd_i.ready) predict_word(cmd_i.cmd, cmd_i.value);
    end
    fail_cnt_o    <= mismatches;
    outstanding_o <= sums_due.size();
  end

endmodule

@@ bench/ring_deque_pair_pop_core_tb.sv @@
// Top of the ring deque pair-pop bench: clock, reset, command stimulus and a
// stalling result sink; checking is left to rdp_pair_sum_checker.
// Depends on rdp_pkg, rdp_if, ring_deque_pair_pop_core and the checker.
module ring_deque_pair_pop_core_tb;
  import rdp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        idle_on;
  int unsigned fail_cnt;
  int unsigned outstanding;

  rdp_cmd_if cmd_w ();
  rdp_res_if res_w ();

  ring_deque_pair_pop_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_w),
    .res_o  (res_w)
  );

  rdp_pair_sum_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_w),
    .res_i         (res_w),
    .fail_cnt_o    (fail_cnt),
    .outstanding_o (outstanding)
  );

  always #6 clk_i = ~clk_i;

  // valid stays high across back-to-back words; only lowered for a gap
  task automatic send_word(input logic [1:0] op, input logic [31:0] val);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      cmd_w.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_w.valid <= 1'b1;
    cmd_w.cmd   <= op;
    cmd_w.value <= val;
    do @(posedge clk_i); while (!cmd_w.ready);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [1:0] pick_push();
    return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
  endfunction

  function automatic logic [1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return CMD_RESERVED;
    if (r < 52) return pick_push();
    return CMD_POP_PAIR;
  endfunction

  initial begin
    rst_ni      = 1'b0;
    idle_on     = 1'b1;
    cmd_w.valid = 1'b0;
    cmd_w.cmd   = CMD_PUSH_FRONT;
    cmd_w.value = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, single elements at the extremes, pairs at the extremes
    send_word(CMD_POP_PAIR,   32'h0);
    send_word(CMD_PUSH_BACK,  32'h7FFF_FFFF);
    send_word(CMD_POP_PAIR,   32'h0);
    send_word(CMD_PUSH_FRONT, 32'h8000_0000);
    send_word(CMD_POP_PAIR,   32'hFFFF_FFFF);
    send_word(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_word(CMD_PUSH_BACK,  32'h7FFF_FFFF);
    send_word(CMD_POP_PAIR,   32'h0);
    send_word(CMD_PUSH_BACK,  32'h8000_0000);
    send_word(CMD_PUSH_FRONT, 32'h8000_0000);
    send_word(CMD_POP_PAIR,   32'h0);
    send_word(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(CMD_PUSH_BACK,  32'h0000_0001);
    send_word(CMD_POP_PAIR,   32'h0);
    // reserved code must leave the deque empty
    send_word(CMD_RESERVED,   32'h1234_5678);
    send_word(CMD_POP_PAIR,   32'h0);
    send_word(CMD_PUSH_BACK,  32'd5);
    send_word(CMD_PUSH_BACK,  32'd7);
    send_word(CMD_PUSH_FRONT, 32'd3);
    send_word(CMD_POP_PAIR,   32'h0);
    send_word(CMD_POP_PAIR,   32'h0);

    // random mix, some stretches without idling on either side
    for (int blk = 0; blk < 7; blk++) begin
      idle_on = (blk % 3 != 2);
      for (int i = 0; i < 97; i++) send_word(pick_op(), pick_value());
    end

    cmd_w.valid <= 1'b0;
    idle_on = 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (fail_cnt == 0 && outstanding == 0) begin
      $display("ring_deque_pair_pop_core test passed");
    end else begin
      $display("ring_deque_pair_pop_core test failed");
    end
    $finish;
  end

  // result sink: random stall before taking each word
  initial begin
    int unsigned stall;
    res_w.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        res_w.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_w.ready <= 1'b1;
      do @(posedge clk_i); while (!res_w.valid);
    end
  end

  initial begin
    #(12 * 300000);
    $display("ring_deque_pair_pop_core test failed");
    $finish;
  end

endmodule
